@@ hw/rtl/stencil_relaxation_3d_assert.svh @@
// Assertion macros for the stencil relaxation core.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef STENCIL_RELAXATION_3D_ASSERT_SVH
`define STENCIL_RELAXATION_3D_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define SR3D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sr3d assertion failed");
// Next-cycle implication, disabled during reset.
`define SR3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sr3d assertion failed");
`else
`define SR3D_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SR3D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/sr3d_pkg.sv @@
// Shared types and constants for the 3D stencil relaxation block.
// No dependencies; imported by the interfaces, the raster, the core and the top.
package sr3d_pkg;

  localparam int POT_W      = 32;  // Q16.16 potential
  localparam int COEF_W     = 32;  // Q8.24 coefficient
  localparam int FRAC_BITS  = 24;
  localparam int ACC_W      = 48;
  localparam int DIM_W      = 7;
  localparam int DIM_MIN    = 3;
  localparam int DIM_RESET  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_DIM_X_DEF = 64;
  localparam int MAX_DIM_Y_DEF = 64;
  localparam int MAX_DIM_Z_DEF = 64;

  // Datapath widths: second difference, full product, shifted term, five-way sum
  localparam int D2_W   = POT_W + 3;
  localparam int PROD_W = D2_W + COEF_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;
  localparam int DIFF_W = POT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X,
    CFG_DIM_Y,
    CFG_DIM_Z,
    CFG_COEF_X,
    CFG_COEF_Y,
    CFG_COEF_Z,
    CFG_SOURCE
  } cfg_idx_t;

  typedef struct packed {
    logic interior;  // center point of this sample is inside the grid
    logic last;      // center point is the final interior point
  } raster_flags_t;

endpackage

@@ hw/rtl/sr3d_in_if.sv @@
// Input channel: one raster sample per item, valid/ready handshake.
// Depends on sr3d_pkg.
interface sr3d_in_if;
  import sr3d_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POT_W-1:0] potential;

  modport source (output valid, output potential, input ready);
  modport sink (input valid, input potential, output ready);
endinterface

@@ hw/rtl/sr3d_out_if.sv @@
// Result channel: relaxed value, running residual and last-point flag.
// Depends on sr3d_pkg.
interface sr3d_out_if;
  import sr3d_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POT_W-1:0] new_potential;
  logic [ACC_W-1:0]        residual_sum;
  logic                    last_point;

  modport source (output valid, output new_potential, output residual_sum,
                  output last_point, input ready);
  modport sink (input valid, input new_potential, input residual_sum,
                input last_point, output ready);
endinterface

@@ hw/rtl/stencil_relaxation_3d.sv @@
// 7-point 3D relaxation engine: takes one raster sample per cycle, one item in
// every cycle when the result side keeps up. Each accepted sample passes five
// registered stages (multipliers in stage 3). Three copies of the two-plane
// store, two read ports each, feed the center and five neighbors at once.
// Synchronous active-low reset clears position, accumulator, pipeline valids
// and config; the plane store is not cleared and needs no pass.
module stencil_relaxation_3d #(
  parameter int MAX_DIM_X = sr3d_pkg::MAX_DIM_X_DEF,
  parameter int MAX_DIM_Y = sr3d_pkg::MAX_DIM_Y_DEF,
  parameter int MAX_DIM_Z = sr3d_pkg::MAX_DIM_Z_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sr3d_in_if.sink                             in_ch,
  sr3d_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [sr3d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sr3d_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sr3d_pkg::*;

  localparam int PLANE = MAX_DIM_Y * MAX_DIM_Z;
  localparam int DEPTH = 2 * PLANE;
  localparam int AW    = $clog2(DEPTH);

  logic [DIM_W-1:0]         dim_x_r, dim_y_r, dim_z_r;
  logic signed [COEF_W-1:0] coef_x_r, coef_y_r, coef_z_r;
  logic signed [POT_W-1:0]  source_r;
  raster_flags_t            flags;
  logic [AW-1:0]            cur_addr, ctr_addr;
  logic                     core_ready, in_acc;
  logic [POT_W-1:0]         xm_w, old_w, ym_w, yp_w, zm_w, zp_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= DIM_W'(DIM_RESET);
      dim_y_r  <= DIM_W'(DIM_RESET);
      dim_z_r  <= DIM_W'(DIM_RESET);
      coef_x_r <= '0;
      coef_y_r <= '0;
      coef_z_r <= '0;
      source_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIM_X:  dim_x_r  <= cfg_data[DIM_W-1:0];
        CFG_DIM_Y:  dim_y_r  <= cfg_data[DIM_W-1:0];
        CFG_DIM_Z:  dim_z_r  <= cfg_data[DIM_W-1:0];
        CFG_COEF_X: coef_x_r <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y: coef_y_r <= cfg_data[COEF_W-1:0];
        CFG_COEF_Z: coef_z_r <= cfg_data[COEF_W-1:0];
        CFG_SOURCE: source_r <= cfg_data[POT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = core_ready;
  assign in_acc      = in_ch.valid && core_ready;

  sr3d_raster #(
    .MAX_DIM_X (MAX_DIM_X),
    .MAX_DIM_Y (MAX_DIM_Y),
    .MAX_DIM_Z (MAX_DIM_Z)
  ) u_raster (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_acc),
    .dim_x    (dim_x_r),
    .dim_y    (dim_y_r),
    .dim_z    (dim_z_r),
    .flags    (flags),
    .cur_addr (cur_addr),
    .ctr_addr (ctr_addr)
  );

  // Copy A: x-1 neighbor (read before overwrite) and center
  sr3d_ram #(.WIDTH(POT_W), .DEPTH(DEPTH)) u_ram_x (
    .clk (clk),
    .we  (in_acc),
    .wa  (cur_addr),
    .wd  (in_ch.potential),
    .re  (in_acc),
    .ra0 (cur_addr),
    .ra1 (ctr_addr),
    .rd0 (xm_w),
    .rd1 (old_w)
  );

  // Copy B: y neighbors
  sr3d_ram #(.WIDTH(POT_W), .DEPTH(DEPTH)) u_ram_y (
    .clk (clk),
    .we  (in_acc),
    .wa  (cur_addr),
    .wd  (in_ch.potential),
    .re  (in_acc),
    .ra0 (ctr_addr - AW'(MAX_DIM_Z)),
    .ra1 (ctr_addr + AW'(MAX_DIM_Z)),
    .rd0 (ym_w),
    .rd1 (yp_w)
  );

  // Copy C: z neighbors
  sr3d_ram #(.WIDTH(POT_W), .DEPTH(DEPTH)) u_ram_z (
    .clk (clk),
    .we  (in_acc),
    .wa  (cur_addr),
    .wd  (in_ch.potential),
    .re  (in_acc),
    .ra0 (ctr_addr - AW'(1)),
    .ra1 (ctr_addr + AW'(1)),
    .rd0 (zm_w),
    .rd1 (zp_w)
  );

  sr3d_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .flags       (flags),
    .load_ready  (core_ready),
    .sample      (in_ch.potential),
    .xm_word     (xm_w),
    .old_word    (old_w),
    .ym_word     (ym_w),
    .yp_word     (yp_w),
    .zm_word     (zm_w),
    .zp_word     (zp_w),
    .coef_x      (coef_x_r),
    .coef_y      (coef_y_r),
    .coef_z      (coef_z_r),
    .source_term (source_r),
    .out_ch      (out_ch)
  );

endmodule

@@ hw/rtl/sr3d_ram.sv @@
// Generic single-write, dual-read RAM with registered, read-first outputs.
// No dependencies.
module sr3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra0,
  input  logic [$clog2(DEPTH)-1:0] ra1,
  output logic [WIDTH-1:0]         rd0,
  output logic [WIDTH-1:0]         rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

endmodule

@@ hw/rtl/sr3d_raster.sv @@
// Raster position tracker: clamps the grid size, flags interior and final
// points, and forms the plane store addresses. Depends on sr3d_pkg.
module sr3d_raster #(
  parameter int MAX_DIM_X = sr3d_pkg::MAX_DIM_X_DEF,
  parameter int MAX_DIM_Y = sr3d_pkg::MAX_DIM_Y_DEF,
  parameter int MAX_DIM_Z = sr3d_pkg::MAX_DIM_Z_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         advance,
  input  logic [sr3d_pkg::DIM_W-1:0]                   dim_x,
  input  logic [sr3d_pkg::DIM_W-1:0]                   dim_y,
  input  logic [sr3d_pkg::DIM_W-1:0]                   dim_z,
  output sr3d_pkg::raster_flags_t                      flags,
  output logic [$clog2(2*MAX_DIM_Y*MAX_DIM_Z)-1:0]     cur_addr,
  output logic [$clog2(2*MAX_DIM_Y*MAX_DIM_Z)-1:0]     ctr_addr
);
  import sr3d_pkg::*;

  localparam int XW    = $clog2(MAX_DIM_X);
  localparam int YW    = $clog2(MAX_DIM_Y);
  localparam int ZW    = $clog2(MAX_DIM_Z);
  localparam int XCW   = ((XW > DIM_W) ? XW : DIM_W) + 1;
  localparam int YCW   = ((YW > DIM_W) ? YW : DIM_W) + 1;
  localparam int ZCW   = ((ZW > DIM_W) ? ZW : DIM_W) + 1;
  localparam int PLANE = MAX_DIM_Y * MAX_DIM_Z;
  localparam int AW    = $clog2(2 * PLANE);

  logic [XW-1:0]  px_r, px_nxt;
  logic [YW-1:0]  py_r, py_nxt;
  logic [ZW-1:0]  pz_r, pz_nxt;
  logic [XCW-1:0] dx, xe;
  logic [YCW-1:0] dy, ye;
  logic [ZCW-1:0] dz, ze;
  logic           z_end, y_end, x_end;
  logic [AW-1:0]  base, plane_off;

  // Clamp each size to [3, max]
  always_comb begin
    if (XCW'(dim_x) < XCW'(DIM_MIN)) begin
      dx = XCW'(DIM_MIN);
    end else if (XCW'(dim_x) > XCW'(MAX_DIM_X)) begin
      dx = XCW'(MAX_DIM_X);
    end else begin
      dx = XCW'(dim_x);
    end
    if (YCW'(dim_y) < YCW'(DIM_MIN)) begin
      dy = YCW'(DIM_MIN);
    end else if (YCW'(dim_y) > YCW'(MAX_DIM_Y)) begin
      dy = YCW'(MAX_DIM_Y);
    end else begin
      dy = YCW'(dim_y);
    end
    if (ZCW'(dim_z) < ZCW'(DIM_MIN)) begin
      dz = ZCW'(DIM_MIN);
    end else if (ZCW'(dim_z) > ZCW'(MAX_DIM_Z)) begin
      dz = ZCW'(MAX_DIM_Z);
    end else begin
      dz = ZCW'(dim_z);
    end
  end

  assign xe = XCW'(px_r);
  assign ye = YCW'(py_r);
  assign ze = ZCW'(pz_r);

  // The sample at x belongs to the center point at x-1
  assign flags.interior = (xe >= XCW'(2)) && (xe + XCW'(1) <= dx) &&
                          (ye >= YCW'(1)) && (ye + YCW'(2) <= dy) &&
                          (ze >= ZCW'(1)) && (ze + ZCW'(2) <= dz);
  assign flags.last     = (xe + XCW'(1) == dx) && (ye + YCW'(2) == dy) &&
                          (ze + ZCW'(2) == dz);

  assign z_end = (ze + ZCW'(1)) >= dz;
  assign y_end = (ye + YCW'(1)) >= dy;
  assign x_end = (xe + XCW'(1)) >= dx;

  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    pz_nxt = pz_r;
    if (z_end) begin
      pz_nxt = '0;
      if (y_end) begin
        py_nxt = '0;
        px_nxt = x_end ? '0 : XW'(xe + XCW'(1));
      end else begin
        py_nxt = YW'(ye + YCW'(1));
      end
    end else begin
      pz_nxt = ZW'(ze + ZCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
    end else if (advance) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
  end

  // Two planes by parity of x; the current sample overwrites plane x-2
  assign plane_off = AW'(PLANE);
  assign base      = AW'(py_r) * AW'(MAX_DIM_Z) + AW'(pz_r);
  assign cur_addr  = px_r[0] ? base + plane_off : base;
  assign ctr_addr  = px_r[0] ? base : base + plane_off;

endmodule

@@ hw/rtl/sr3d_core.sv @@
// Stencil arithmetic pipeline: second differences, Q8.24 products, saturating
// sum and residual accumulator. Depends on sr3d_pkg, sr3d_out_if and the macros.
`include "stencil_relaxation_3d_assert.svh"
module sr3d_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  sr3d_pkg::raster_flags_t              flags,
  output logic                                 load_ready,
  input  logic signed [sr3d_pkg::POT_W-1:0]    sample,
  input  logic [sr3d_pkg::POT_W-1:0]           xm_word,
  input  logic [sr3d_pkg::POT_W-1:0]           old_word,
  input  logic [sr3d_pkg::POT_W-1:0]           ym_word,
  input  logic [sr3d_pkg::POT_W-1:0]           yp_word,
  input  logic [sr3d_pkg::POT_W-1:0]           zm_word,
  input  logic [sr3d_pkg::POT_W-1:0]           zp_word,
  input  logic signed [sr3d_pkg::COEF_W-1:0]   coef_x,
  input  logic signed [sr3d_pkg::COEF_W-1:0]   coef_y,
  input  logic signed [sr3d_pkg::COEF_W-1:0]   coef_z,
  input  logic signed [sr3d_pkg::POT_W-1:0]    source_term,
  sr3d_out_if.source                           out_ch
);
  import sr3d_pkg::*;

  logic r1, r2, r3, r4, r5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1: sample and flag; store words arrive registered from the RAMs
  logic signed [POT_W-1:0]  smp1_r;
  logic                     last1_r;
  // Stage 2: second differences
  logic signed [D2_W-1:0]   d2x_r, d2y_r, d2z_r, d2x_nxt, d2y_nxt, d2z_nxt;
  logic signed [POT_W-1:0]  old2_r;
  logic                     last2_r;
  // Stage 3: scaled terms
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [TERM_W-1:0] tx_r, ty_r, tz_r;
  logic signed [POT_W-1:0]  old3_r;
  logic                     last3_r;
  // Stage 4: saturated value and magnitude of change
  logic signed [SUM_W-1:0]  sum_w;
  logic                     ovf;
  logic signed [POT_W-1:0]  new_nxt, new4_r;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag_nxt, mag4_r;
  logic                     last4_r;
  // Stage 5: result register and accumulator
  logic [ACC_W:0]           acc_sum;
  logic [ACC_W-1:0]         acc_nxt, acc_r;
  logic signed [POT_W-1:0]  new5_r;
  logic [ACC_W-1:0]         res5_r;
  logic                     last5_r;

  assign r5         = !v5_r || out_ch.ready;
  assign r4         = !v4_r || r5;
  assign r3         = !v3_r || r4;
  assign r2         = !v2_r || r3;
  assign r1         = !v1_r || r2;
  assign load_ready = r1;

  assign d2x_nxt = D2_W'(smp1_r) + D2_W'($signed(xm_word))
                   - (D2_W'($signed(old_word)) <<< 1);
  assign d2y_nxt = D2_W'($signed(yp_word)) + D2_W'($signed(ym_word))
                   - (D2_W'($signed(old_word)) <<< 1);
  assign d2z_nxt = D2_W'($signed(zp_word)) + D2_W'($signed(zm_word))
                   - (D2_W'($signed(old_word)) <<< 1);

  assign px = PROD_W'(d2x_r) * PROD_W'(coef_x);
  assign py = PROD_W'(d2y_r) * PROD_W'(coef_y);
  assign pz = PROD_W'(d2z_r) * PROD_W'(coef_z);

  assign sum_w = SUM_W'(old3_r) + SUM_W'(source_term) + SUM_W'(tx_r)
                 + SUM_W'(ty_r) + SUM_W'(tz_r);
  // Saturate when the result sign bit and the bits above it disagree
  assign ovf     = !(&sum_w[SUM_W-1:POT_W-1]) && (|sum_w[SUM_W-1:POT_W-1]);
  assign new_nxt = !ovf ? sum_w[POT_W-1:0] :
                   sum_w[SUM_W-1] ? {1'b1, {(POT_W-1){1'b0}}} :
                                    {1'b0, {(POT_W-1){1'b1}}};
  assign diff    = DIFF_W'(new_nxt) - DIFF_W'(old3_r);
  assign mag_nxt = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  assign acc_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(mag4_r);
  assign acc_nxt = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      if (r1) begin
        v1_r <= in_valid && flags.interior;
      end
      if (r2) begin
        v2_r <= v1_r;
      end
      if (r3) begin
        v3_r <= v2_r;
      end
      if (r4) begin
        v4_r <= v3_r;
      end
      if (r5) begin
        v5_r <= v4_r;
      end
      // Clear after the final interior point
      if (r5 && v4_r) begin
        acc_r <= last4_r ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      smp1_r  <= sample;
      last1_r <= flags.last;
    end
    if (r2 && v1_r) begin
      d2x_r   <= d2x_nxt;
      d2y_r   <= d2y_nxt;
      d2z_r   <= d2z_nxt;
      old2_r  <= $signed(old_word);
      last2_r <= last1_r;
    end
    if (r3 && v2_r) begin
      tx_r    <= px[PROD_W-1:FRAC_BITS];
      ty_r    <= py[PROD_W-1:FRAC_BITS];
      tz_r    <= pz[PROD_W-1:FRAC_BITS];
      old3_r  <= old2_r;
      last3_r <= last2_r;
    end
    if (r4 && v3_r) begin
      new4_r  <= new_nxt;
      mag4_r  <= mag_nxt;
      last4_r <= last3_r;
    end
    if (r5 && v4_r) begin
      new5_r  <= new4_r;
      res5_r  <= acc_nxt;
      last5_r <= last4_r;
    end
  end

  assign out_ch.valid         = v5_r;
  assign out_ch.new_potential = new5_r;
  assign out_ch.residual_sum  = res5_r;
  assign out_ch.last_point    = last5_r;

  `SR3D_ASSERT_NEXT(a_acc_clear, clk, rst_n, r5 && v4_r && last4_r, acc_r == '0)
  `SR3D_ASSERT_NEXT(a_acc_grow, clk, rst_n, r5 && v4_r && !last4_r, acc_r >= $past(acc_r))
  `SR3D_ASSERT_NEXT(a_res_tracks, clk, rst_n, r5 && v4_r, out_ch.last_point || out_ch.residual_sum == acc_r)
  `SR3D_ASSERT_IMPL(a_stall_full, clk, rst_n, !load_ready, v1_r && v2_r && v3_r && v4_r && v5_r && !out_ch.ready)

endmodule

@@ bench/tb.sv @@
// Self-checking bench for stencil_relaxation_3d: streams whole potential grids through the
// block, predicts every relaxed interior point and the running residual, and checks them.
// Depends on sr3d_pkg, sr3d_in_if, sr3d_out_if and stencil_relaxation_3d from the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sr3d_pkg::*;

  localparam int unsigned SPAN_X = MAX_DIM_X_DEF;
  localparam int unsigned SPAN_Y = MAX_DIM_Y_DEF;
  localparam int unsigned SPAN_Z = MAX_DIM_Z_DEF;
  localparam int unsigned PLANE_WORDS = SPAN_Y * SPAN_Z;
  localparam int unsigned SETTLE_CYCLES = 8;     // margin after the queues and the driver go idle
  localparam int unsigned WATCHDOG_LIMIT = 2000; // must outlast the long receiver hold
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned STEADY_AFTER = 160;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned REPORT_CAP = 100;
  localparam logic signed [47:0] POT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] POT_LO = 48'shFFFF_8000_0000;

  typedef struct {
    logic [POT_W-1:0] new_potential;
    logic [ACC_W-1:0] residual_sum;
    logic             last_point;
  } relax_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  drv_valid = 1'b0;
  logic [POT_W-1:0]      drv_potential = '0;
  logic                  rcv_ready = 1'b0;

  sr3d_in_if in_ch ();
  sr3d_out_if out_ch ();

  assign in_ch.valid = drv_valid;
  assign in_ch.potential = drv_potential;
  assign out_ch.ready = rcv_ready;

  stencil_relaxation_3d uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copy and grid state of the relaxation engine
  logic [DIM_W-1:0]        dim_x_reg = DIM_W'(DIM_RESET);
  logic [DIM_W-1:0]        dim_y_reg = DIM_W'(DIM_RESET);
  logic [DIM_W-1:0]        dim_z_reg = DIM_W'(DIM_RESET);
  logic signed [31:0]      coef_x_reg = '0;
  logic signed [31:0]      coef_y_reg = '0;
  logic signed [31:0]      coef_z_reg = '0;
  logic signed [31:0]      source_reg = '0;
  int unsigned             pos_x = 0;
  int unsigned             pos_y = 0;
  int unsigned             pos_z = 0;
  logic [ACC_W-1:0]        change_sum = '0;
  logic signed [POT_W-1:0] plane_img [2*PLANE_WORDS];

  logic [POT_W-1:0] pending_samples [$];
  relax_result_t    expected_points [$];

  int unsigned samples_in = 0;
  int unsigned fed_total = 0;
  int unsigned points_out = 0;
  int unsigned grid_ends = 0;
  int unsigned resizes = 0;
  int unsigned errors = 0;
  logic        steady = 1'b0;

  int unsigned src_gap = 0;
  int unsigned src_pct = 10;
  int unsigned src_tick = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_pct = 10;
  int unsigned sink_tick = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned quiet = 0;

  function automatic int unsigned span_of(logic [DIM_W-1:0] v, int unsigned top);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void step_pos(inout int unsigned x, inout int unsigned y,
                                   inout int unsigned z);
    if (z + 1 >= span_of(dim_z_reg, SPAN_Z)) begin
      z = 0;
      if (y + 1 >= span_of(dim_y_reg, SPAN_Y)) begin
        y = 0;
        x = (x + 1 >= span_of(dim_x_reg, SPAN_X)) ? 0 : x + 1;
      end else begin
        y = y + 1;
      end
    end else begin
      z = z + 1;
    end
  endfunction

  // Samples still needed to bring the raster position back to the origin
  function automatic int unsigned grid_left();
    int unsigned x, y, z, n;
    x = pos_x;
    y = pos_y;
    z = pos_z;
    n = 0;
    do begin
      step_pos(x, y, z);
      n++;
    end while (x != 0 || y != 0 || z != 0);
    return n;
  endfunction

  // Q8.24 coefficient times second difference, floored back to Q16.16
  function automatic logic signed [43:0] scaled_term(logic signed [34:0] d2,
                                                     logic signed [31:0] k);
    logic signed [66:0] prod;
    prod = d2 * k;
    return 44'(prod >>> FRAC_BITS);
  endfunction

  task automatic relax_point(logic signed [POT_W-1:0] sample);
    int unsigned             dx, dy, dz, here, mid;
    logic signed [POT_W-1:0] old_v;
    logic signed [34:0]      lap_x, lap_y, lap_z;
    logic signed [47:0]      total;
    logic signed [POT_W-1:0] relaxed;
    logic signed [POT_W:0]   delta;
    logic [POT_W:0]          change;
    logic [ACC_W:0]          grown;
    relax_result_t           r;
    dx = span_of(dim_x_reg, SPAN_X);
    dy = span_of(dim_y_reg, SPAN_Y);
    dz = span_of(dim_z_reg, SPAN_Z);
    here = (pos_x % 2) * PLANE_WORDS + pos_y * SPAN_Z + pos_z;
    if (pos_x >= 2 && pos_x <= dx - 1 && pos_y >= 1 && pos_y <= dy - 2 &&
        pos_z >= 1 && pos_z <= dz - 2) begin
      mid = ((pos_x - 1) % 2) * PLANE_WORDS + pos_y * SPAN_Z + pos_z;
      old_v = plane_img[mid];
      lap_x = sample + plane_img[here] - old_v - old_v;
      lap_y = plane_img[mid + SPAN_Z] + plane_img[mid - SPAN_Z] - old_v - old_v;
      lap_z = plane_img[mid + 1] + plane_img[mid - 1] - old_v - old_v;
      total = old_v + source_reg + scaled_term(lap_x, coef_x_reg)
              + scaled_term(lap_y, coef_y_reg) + scaled_term(lap_z, coef_z_reg);
      if (total > POT_HI) begin
        relaxed = 32'h7FFF_FFFF;
      end else if (total < POT_LO) begin
        relaxed = 32'h8000_0000;
      end else begin
        relaxed = total[POT_W-1:0];
      end
      delta = relaxed - old_v;
      change = delta[POT_W] ? -delta : delta;
      grown = change_sum + change;
      change_sum = grown[ACC_W] ? '1 : grown[ACC_W-1:0];
      r.new_potential = relaxed;
      r.residual_sum = change_sum;
      r.last_point = (pos_x == dx - 1 && pos_y == dy - 2 && pos_z == dz - 2);
      expected_points.push_back(r);
      if (r.last_point) change_sum = '0;
    end
    plane_img[here] = sample;
    step_pos(pos_x, pos_y, pos_z);
  endtask

  function automatic logic [31:0] draw_sample(int unsigned pick);
    logic [31:0] r;
    r = $urandom;
    if (pick < 15) begin
      case (r[2:0])
        3'd0: return 32'h7FFF_FFFF;
        3'd1: return 32'h8000_0000;
        3'd2: return 32'h0000_0000;
        3'd3: return 32'hFFFF_FFFF;
        3'd4: return 32'h0001_0000;
        3'd5: return 32'hFFFF_0000;
        3'd6: return 32'h0000_0001;
        default: return 32'h7FFF_0000;
      endcase
    end
    if (pick < 40) return r;
    return {{12{r[19]}}, r[19:0]};
  endfunction

  function automatic logic [31:0] draw_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0, 1: return {{8{r[23]}}, r[23:0]};
      2: return r;
      default: begin
        case (r[1:0])
          2'd0: return 32'h7FFF_FFFF;
          2'd1: return 32'h8000_0000;
          2'd2: return 32'h0000_0000;
          default: return 32'h0100_0000;
        endcase
      end
    endcase
  endfunction

  // Dimension write with junk in the unused upper bits; a few values need clamping
  function automatic logic [31:0] rand_dim();
    logic [31:0] r;
    r = $urandom;
    r[DIM_W-1:0] = ($urandom_range(9) == 0) ? 7'($urandom_range(12)) : 7'($urandom_range(3, 6));
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || drv_valid || expected_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DIM_X:  dim_x_reg = val[DIM_W-1:0];
      CFG_DIM_Y:  dim_y_reg = val[DIM_W-1:0];
      CFG_DIM_Z:  dim_z_reg = val[DIM_W-1:0];
      CFG_COEF_X: coef_x_reg = val;
      CFG_COEF_Y: coef_y_reg = val;
      CFG_COEF_Z: coef_z_reg = val;
      CFG_SOURCE: source_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] src);
    settle();
    set_reg(CFG_DIM_X, dx);
    set_reg(CFG_DIM_Y, dy);
    set_reg(CFG_DIM_Z, dz);
    set_reg(CFG_COEF_X, cx);
    set_reg(CFG_COEF_Y, cy);
    set_reg(CFG_COEF_Z, cz);
    set_reg(CFG_SOURCE, src);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      pending_samples.push_back(draw_sample($urandom_range(99)));
    fed_total += n;
  endtask

  // Sender: hold an offered item until taken, otherwise idle in bursts or load the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        relax_point(drv_potential);
        samples_in <= samples_in + 1;
      end
      src_tick++;
      if (src_tick % 64 == 0)
        src_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 35);
      if (drv_valid && !in_ch.ready) begin
        // hold
      end else if (src_gap != 0) begin
        src_gap--;
        drv_valid <= 1'b0;
      end else if (pending_samples.size() != 0 && !steady && $urandom_range(99) < src_pct) begin
        src_gap = $urandom_range(9);
        drv_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        drv_valid <= 1'b1;
        drv_potential <= pending_samples.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted result, then pick the next ready value
  always @(posedge clk) begin
    relax_result_t want;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected item, residual_sum", '0, out_ch.residual_sum);
        end else begin
          want = expected_points.pop_front();
          if (out_ch.new_potential !== want.new_potential)
            report_mismatch("new_potential", ACC_W'(want.new_potential),
                            ACC_W'($unsigned(out_ch.new_potential)));
          if (out_ch.residual_sum !== want.residual_sum)
            report_mismatch("residual_sum", want.residual_sum, out_ch.residual_sum);
          if (out_ch.last_point !== want.last_point)
            report_mismatch("last_point", ACC_W'(want.last_point),
                            ACC_W'(out_ch.last_point));
        end
        points_out++;
        if (out_ch.last_point === 1'b1) grid_ends++;
      end
      sink_tick++;
      if (sink_tick % 64 == 0)
        sink_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 35);
      // Long stall once, so the pipeline fills and backs up into the input
      if (!hold_done && samples_in >= HOLD_AT) begin
        hold_left = $urandom_range(150, 250);
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        rcv_ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < sink_pct) begin
        sink_gap = $urandom_range(9);
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (drv_valid && in_ch.ready) || (out_ch.valid && rcv_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet);
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned random_base, total, cut, axis;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest grid with everything at its limit: positive, then negative saturation
    for (int p = 0; p < 2; p++) begin
      if (p == 0)
        configure(32'd3, 32'd3, 32'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
      else
        configure(32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
      for (int i = 0; i < 27; i++)
        pending_samples.push_back(i != 13 ? 32'h7FFF_FFFF : (p == 0 ? 32'h8000_0000 : '0));
      fed_total += 27;
    end

    // One random axis at full length through an over-range write, the others at minimum
    axis = $urandom_range(2);
    configure(axis == 0 ? 32'd127 : 32'd3, axis == 1 ? 32'd127 : 32'd0,
              axis == 2 ? 32'd127 : 32'd1, draw_coef(), draw_coef(), draw_coef(),
              draw_sample(50));
    feed(grid_left());

    random_base = fed_total;
    while (fed_total - random_base < RANDOM_ITEMS) begin
      if (fed_total - random_base >= STEADY_AFTER) steady = 1'b1;
      configure(rand_dim(), rand_dim(), rand_dim(), draw_coef(), draw_coef(), draw_coef(),
                draw_sample($urandom_range(99)));
      total = grid_left();
      if (resizes == 0 || $urandom_range(4) == 0) begin
        // Resize the slow axis partway through the grid
        cut = $urandom_range(1, total - 1);
        feed(cut);
        settle();
        set_reg(CFG_DIM_X, rand_dim());
        set_reg(CFG_SOURCE, draw_sample($urandom_range(99)));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        resizes++;
        feed(grid_left());
      end else begin
        feed(total);
      end
    end

    settle();
    $display("run covered %0d samples, %0d relaxed points, %0d grid ends, %0d mid-grid resizes",
             samples_in, points_out, grid_ends, resizes);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ stencil_relaxation_3d.f @@
+incdir+hw/rtl
hw/rtl/sr3d_pkg.sv
hw/rtl/sr3d_in_if.sv
hw/rtl/sr3d_out_if.sv
hw/rtl/sr3d_ram.sv
hw/rtl/sr3d_raster.sv
hw/rtl/sr3d_core.sv
hw/rtl/stencil_relaxation_3d.sv
bench/tb.sv
